// File: rtl/isl_pkg.sv
// Shared types and constants for the indexed sequence list.
package isl_pkg;

    localparam int ISL_CAPACITY    = 16;
    localparam int ISL_VALUE_WIDTH = 32;

    localparam int KIND_W   = 4;
    localparam int POS_W    = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 4'd0,
        K_PUSH_BACK  = 4'd1,
        K_INSERT_AT  = 4'd2,
        K_READ       = 4'd3,
        K_WRITE      = 4'd4,
        K_POP_FRONT  = 4'd5,
        K_POP_BACK   = 4'd6,
        K_REMOVE_AT  = 4'd7,
        K_CLEAR      = 4'd8
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // What every cell does, relative to the broadcast index.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_WRITE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
    } t_cell_ctl;

endpackage

// File: rtl/isl_cell.sv
// One storage cell of the list: holds, loads, or takes a neighbor's value.
module isl_cell #(
    parameter int VALUE_WIDTH = isl_pkg::ISL_VALUE_WIDTH,
    parameter int IW          = 4,
    parameter int INDEX       = 0
) (
    input  logic                   i_clk,
    input  isl_pkg::t_cell_ctl     i_ctl,
    input  logic [IW-1:0]          i_index,
    input  logic [VALUE_WIDTH-1:0] i_new,
    input  logic [VALUE_WIDTH-1:0] i_prev,
    input  logic [VALUE_WIDTH-1:0] i_next,
    output logic [VALUE_WIDTH-1:0] o_value
);
    import isl_pkg::*;

    localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (MY_INDEX > i_index) begin
                    n_value = i_prev;
                end else if (MY_INDEX == i_index) begin
                    n_value = i_new;
                end
            end
            CELL_REMOVE: begin
                if (MY_INDEX >= i_index) begin
                    n_value = i_next;
                end
            end
            CELL_WRITE: begin
                if (MY_INDEX == i_index) begin
                    n_value = i_new;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// File: rtl/indexed_sequence_list.sv
// Top level of the indexed sequence list: request decode, cell row, result register.
//
//  channel | direction | handshake          | payload
//  request | in        | i_valid / o_stall  | i_kind, i_position, i_data_in
//  result  | out       | o_valid / i_stall  | o_data_out, o_status, o_entry_count
//
// Every request completes on its accepting edge: the whole cell row shifts in parallel
// and the result lands in the output register on the accepting edge.
// One request per cycle is sustained while the result is not stalled; the limit is the single result register.
// Reset clears the count and the result valid; cell contents are left as is.
// While a result is stalled, o_stall follows i_stall and no request is taken.
module indexed_sequence_list #(
    parameter int CAPACITY    = isl_pkg::ISL_CAPACITY,
    parameter int VALUE_WIDTH = isl_pkg::ISL_VALUE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [isl_pkg::KIND_W-1:0]     i_kind,
    input  logic [isl_pkg::POS_W-1:0]      i_position,
    input  logic [isl_pkg::DATA_W-1:0]     i_data_in,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [isl_pkg::DATA_W-1:0]     o_data_out,
    output logic [isl_pkg::STATUS_W-1:0]   o_status,
    output logic [isl_pkg::COUNT_W-1:0]    o_entry_count
);
    import isl_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int EXTW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int DW   = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_valid;
    logic                   n_valid;
    logic [DATA_W-1:0]      r_data_out;
    logic [DATA_W-1:0]      n_data_out;
    t_status                r_status;
    t_status                n_status;
    logic [COUNT_W-1:0]     r_entry_count;

    logic                   accept;
    logic                   full;
    logic                   empty;
    logic [CMPW-1:0]        pos_ext;
    logic [CMPW-1:0]        cnt_ext;
    logic [IW-1:0]          idx;
    t_cell_op               op;
    t_cell_ctl              cell_ctl;
    logic                   take_read;
    logic [DW-1:0]          din_wide;
    logic [VALUE_WIDTH-1:0] new_value;
    logic [VALUE_WIDTH-1:0] rd_value;
    logic [DW-1:0]          rd_wide;
    logic [EXTW-1:0]        cnt_wide;
    logic [VALUE_WIDTH-1:0] w_cells [CAPACITY];

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign full    = (r_count == CAP_COUNT);
    assign empty   = (r_count == '0);
    assign pos_ext = CMPW'(i_position);
    assign cnt_ext = CMPW'(r_count);

    assign din_wide  = DW'(i_data_in);
    assign new_value = din_wide[VALUE_WIDTH-1:0];

    // Request decode: bounds checks, the broadcast index and the new count.
    always_comb begin
        op        = CELL_HOLD;
        idx       = IW'(i_position);
        n_status  = ST_OK;
        n_count   = r_count;
        take_read = 1'b0;
        case (i_kind)
            K_PUSH_FRONT: begin
                idx = '0;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    op      = CELL_INSERT;
                    n_count = r_count + CW'(1);
                end
            end
            K_PUSH_BACK: begin
                idx = IW'(r_count);
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    op      = CELL_INSERT;
                    n_count = r_count + CW'(1);
                end
            end
            K_INSERT_AT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else if (pos_ext > cnt_ext) begin
                    n_status = ST_RANGE;
                end else begin
                    op      = CELL_INSERT;
                    n_count = r_count + CW'(1);
                end
            end
            K_READ: begin
                if (pos_ext >= cnt_ext) begin
                    n_status = ST_RANGE;
                end else begin
                    take_read = 1'b1;
                end
            end
            K_WRITE: begin
                if (pos_ext >= cnt_ext) begin
                    n_status = ST_RANGE;
                end else begin
                    op = CELL_WRITE;
                end
            end
            K_POP_FRONT: begin
                idx = '0;
                if (empty) begin
                    n_status = ST_RANGE;
                end else begin
                    op        = CELL_REMOVE;
                    take_read = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
            K_POP_BACK: begin
                idx = IW'(r_count - CW'(1));
                if (empty) begin
                    n_status = ST_RANGE;
                end else begin
                    op        = CELL_REMOVE;
                    take_read = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
            K_REMOVE_AT: begin
                if (pos_ext >= cnt_ext) begin
                    n_status = ST_RANGE;
                end else begin
                    op        = CELL_REMOVE;
                    take_read = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
            K_CLEAR: begin
                n_count = '0;
            end
            default: begin
                op = CELL_HOLD;
            end
        endcase
    end

    assign cell_ctl.op = accept ? op : CELL_HOLD;

    // Row of cells; each passes its value to its neighbors.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] prev_value;
        logic [VALUE_WIDTH-1:0] next_value;

        if (g == 0) begin : g_first
            assign prev_value = new_value;
        end else begin : g_mid_prev
            assign prev_value = w_cells[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_value = w_cells[g];
        end else begin : g_mid_next
            assign next_value = w_cells[g+1];
        end

        isl_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .IW          (IW),
            .INDEX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_index (idx),
            .i_new   (new_value),
            .i_prev  (prev_value),
            .i_next  (next_value),
            .o_value (w_cells[g])
        );
    end

    assign rd_value   = w_cells[idx];
    assign rd_wide    = DW'(rd_value);
    assign n_data_out = take_read ? rd_wide[DATA_W-1:0] : '0;
    assign cnt_wide   = EXTW'(n_count);

    always_comb begin
        n_valid = r_valid && i_stall;
        if (accept) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    // Result beat payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data_out    <= n_data_out;
            r_status      <= n_status;
            r_entry_count <= cnt_wide[COUNT_W-1:0];
        end
    end

    assign o_valid       = r_valid;
    assign o_data_out    = r_data_out;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_COUNT)
        else $error("entry count above capacity");

    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_count))
        else $error("entry count changed without a request beat");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted request produced no result");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_data_out == '0))
        else $error("failed request returned data");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (n_status == ST_FULL) |=> (r_count == CAP_COUNT))
        else $error("full status with room left");

endmodule
